// ----- design/esdf_pkg.sv -----
package esdf_pkg;

   localparam int VALUE_WIDTH = 48;
   localparam int FRAC_BITS   = 24;
   localparam int GAMMA_W     = 26;
   localparam int EPS_W       = 25;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam int TDATA_IN_W  = ((3 * VALUE_WIDTH + 7) / 8) * 8;
   localparam int TDATA_OUT_W = ((3 * VALUE_WIDTH + 7) / 8) * 8;

   // iterative unit sizing
   localparam int MUL_CHUNK = 16;
   localparam int MUL_STEPS = (VALUE_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int MUL_PAD_W = MUL_STEPS * MUL_CHUNK;
   localparam int ACC_W     = VALUE_WIDTH + MUL_PAD_W;
   localparam int NUM_W     = VALUE_WIDTH + FRAC_BITS;
   localparam int REM_W     = VALUE_WIDTH + 1;
   localparam int SQ_STEPS  = (NUM_W + 1) / 2;
   localparam int SQ_W      = 2 * SQ_STEPS;
   localparam int SR_W      = SQ_STEPS + 3;
   localparam int WIDE_W    = (ACC_W > NUM_W) ? ACC_W : NUM_W;
   localparam int CNT_W     = $clog2(NUM_W + 1);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic        [VALUE_WIDTH-1:0] mag_type;

   localparam mag_type VMAX   = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam mag_type QONE_M = mag_type'(1) << FRAC_BITS;

   localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(23488102);
   localparam logic [EPS_W-1:0]   EPS_RESET   = EPS_W'(8388608);

   typedef enum logic {
      CSR_GAMMA,
      CSR_EPS
   } csr_reg_type;

   typedef enum logic [1:0] {
      FLUX_OK,
      FLUX_SAT,
      FLUX_BAD
   } flux_status_type;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } iter_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_U,
      ST_MUL_MU,
      ST_PREP,
      ST_MUL_P,
      ST_PCHK,
      ST_MUL_GP,
      ST_DIV_T,
      ST_SQRT_C,
      ST_FLUX,
      ST_MUL_F2,
      ST_FACE,
      ST_LAM1,
      ST_LAM2,
      ST_MUL_EL,
      ST_TERM_PREP,
      ST_MUL_TERM,
      ST_TERM_SUB,
      ST_OUT,
      ST_COMMIT
   } esdf_state_type;

   typedef struct packed {
      esdf_state_type step;
      logic           start;
      logic           load;
      logic           write_out;
      logic [1:0]     idx;
   } ctrl_cmd_type;

   typedef struct packed {
      logic unit_busy;
      logic unit_done;
      logic cell_bad;
      logic prev_bad;
      logic no_face;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      value_type val;
      logic      ovf;
   } sat_type;

   function automatic sat_type sat_mag(input logic neg, input logic [WIDE_W-1:0] m);
      sat_type r;
      mag_type mm;
      if (m > WIDE_W'(VMAX)) begin
         mm    = VMAX;
         r.ovf = 1'b1;
      end else begin
         mm    = m[VALUE_WIDTH-1:0];
         r.ovf = 1'b0;
      end
      r.val = neg ? $signed(-mm) : $signed(mm);
      return r;
   endfunction

   function automatic value_type half_val(input value_type a);
      mag_type m;
      m = a[VALUE_WIDTH-1] ? -$unsigned(a) : $unsigned(a);
      m = m >> 1;
      return a[VALUE_WIDTH-1] ? $signed(-m) : $signed(m);
   endfunction

   function automatic sat_type sat_add(input value_type a, input value_type b);
      logic signed [VALUE_WIDTH:0] s;
      logic        [VALUE_WIDTH:0] m;
      s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
      m = s[VALUE_WIDTH] ? -$unsigned(s) : $unsigned(s);
      return sat_mag(s[VALUE_WIDTH], WIDE_W'(m));
   endfunction

   function automatic sat_type sat_sub(input value_type a, input value_type b);
      logic signed [VALUE_WIDTH:0] s;
      logic        [VALUE_WIDTH:0] m;
      s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
      m = s[VALUE_WIDTH] ? -$unsigned(s) : $unsigned(s);
      return sat_mag(s[VALUE_WIDTH], WIDE_W'(m));
   endfunction

endpackage

// ----- design/esdf_iter.sv -----
module esdf_iter import esdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  iter_op_type op,
   input  value_type   a,
   input  value_type   b,
   output logic        busy,
   output logic        done,
   output value_type   result,
   output logic        ovf
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   iter_op_type          op_ff, op_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   mag_type              ma_ff, ma_in;
   mag_type              dvs_ff, dvs_in;
   logic [MUL_PAD_W-1:0] mb_ff, mb_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [NUM_W-1:0]     quot_ff, quot_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [SQ_W-1:0]      rad_ff, rad_in;
   logic [SR_W-1:0]      srem_ff, srem_in;
   logic [SQ_STEPS-1:0]  root_ff, root_in;
   value_type            result_ff, result_in;
   logic                 ovf_ff, ovf_in;

   mag_type                        ma, mb;
   logic [VALUE_WIDTH+MUL_CHUNK-1:0] pp;
   logic [REM_W-1:0]               rem_sh;
   logic                           div_ge;
   logic [SR_W-1:0]                srem_sh, trial;
   logic                           sq_ge;
   sat_type                        fin;

   always_comb begin
      ma = a[VALUE_WIDTH-1] ? -$unsigned(a) : $unsigned(a);
      mb = b[VALUE_WIDTH-1] ? -$unsigned(b) : $unsigned(b);

      pp      = ma_ff * mb_ff[MUL_PAD_W-1 -: MUL_CHUNK];
      rem_sh  = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
      div_ge  = rem_sh >= REM_W'(dvs_ff);
      srem_sh = {srem_ff[SR_W-3:0], rad_ff[SQ_W-1 -: 2]};
      trial   = SR_W'({root_ff, 2'b01});
      sq_ge   = srem_sh >= trial;

      case (op_ff)
         OP_MUL:  fin = sat_mag(neg_ff, WIDE_W'(acc_ff >> FRAC_BITS));
         OP_DIV:  fin = sat_mag(neg_ff, WIDE_W'(quot_ff));
         OP_SQRT: fin = sat_mag(1'b0, WIDE_W'(root_ff));
         default: fin = sat_mag(1'b0, '0);
      endcase
      if (zero_ff) begin
         fin = sat_mag(1'b0, '0);
      end

      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      cnt_in    = cnt_ff;
      ma_in     = ma_ff;
      dvs_in    = dvs_ff;
      mb_in     = mb_ff;
      acc_in    = acc_ff;
      num_in    = num_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      rad_in    = rad_ff;
      srem_in   = srem_ff;
      root_in   = root_ff;
      result_in = result_ff;
      ovf_in    = ovf_ff;

      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            op_in   = op;
            neg_in  = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
            ma_in   = ma;
            dvs_in  = mb;
            acc_in  = '0;
            quot_in = '0;
            rem_in  = '0;
            srem_in = '0;
            root_in = '0;
            mb_in   = MUL_PAD_W'(mb) << (MUL_PAD_W - VALUE_WIDTH);
            num_in  = NUM_W'(ma) << FRAC_BITS;
            rad_in  = SQ_W'(ma) << FRAC_BITS;
            case (op)
               OP_MUL: begin
                  cnt_in  = CNT_W'(MUL_STEPS);
                  zero_in = 1'b0;
               end
               OP_DIV: begin
                  cnt_in  = CNT_W'(NUM_W);
                  zero_in = (mb == '0);
               end
               OP_SQRT: begin
                  cnt_in  = CNT_W'(SQ_STEPS);
                  zero_in = a[VALUE_WIDTH-1] || (a == '0);
               end
               default: begin
                  cnt_in  = '0;
                  zero_in = 1'b1;
               end
            endcase
         end
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
         case (op_ff)
            OP_MUL: begin
               acc_in = (acc_ff << MUL_CHUNK) + ACC_W'(pp);
               mb_in  = mb_ff << MUL_CHUNK;
            end
            OP_DIV: begin
               rem_in  = div_ge ? rem_sh - REM_W'(dvs_ff) : rem_sh;
               quot_in = {quot_ff[NUM_W-2:0], div_ge};
               num_in  = num_ff << 1;
            end
            OP_SQRT: begin
               srem_in = sq_ge ? srem_sh - trial : srem_sh;
               root_in = {root_ff[SQ_STEPS-2:0], sq_ge};
               rad_in  = rad_ff << 2;
            end
            default: begin
               cnt_in = '0;
            end
         endcase
      end else begin
         // all digits in, truncate and saturate
         busy_in   = 1'b0;
         done_in   = 1'b1;
         result_in = fin.val;
         ovf_in    = fin.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff     <= op_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      cnt_ff    <= cnt_in;
      ma_ff     <= ma_in;
      dvs_ff    <= dvs_in;
      mb_ff     <= mb_in;
      acc_ff    <= acc_in;
      num_ff    <= num_in;
      quot_ff   <= quot_in;
      rem_ff    <= rem_in;
      rad_ff    <= rad_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      result_ff <= result_in;
      ovf_ff    <= ovf_in;
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = result_ff;
   assign ovf    = ovf_ff;

endmodule

// ----- design/esdf_datapath.sv -----
module esdf_datapath import esdf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status,
   input  logic [GAMMA_W-1:0] gamma_ratio,
   input  logic [EPS_W-1:0]   dissipation_eps,
   input  value_type          in_density,
   input  value_type          in_momentum,
   input  value_type          in_energy,
   input  logic               in_first,
   output logic               out_valid,
   input  logic               out_ready,
   output value_type          out_mass,
   output value_type          out_momentum,
   output value_type          out_energy,
   output flux_status_type    out_status
);

   value_type rho_ff, rho_in, m_ff, m_in, e_ff, e_in;
   value_type u_ff, u_in, mu_ff, mu_in, p_ff, p_in, c_ff, c_in;
   value_type f1_ff, f1_in, f2_ff, f2_in;
   value_type ta_ff, ta_in, tb_ff, tb_in, fa_ff, fa_in, el_ff, el_in;
   value_type res_ff [3];
   value_type res_in [3];
   logic      no_face_ff, no_face_in, bad_ff, bad_in;
   logic      ovf_ff, ovf_in, cell_ovf_ff, cell_ovf_in;

   value_type prho_ff, prho_in, pm_ff, pm_in, pe_ff, pe_in;
   value_type pf0_ff, pf0_in, pf1_ff, pf1_in, pf2_ff, pf2_in;
   value_type pu_ff, pu_in, pc_ff, pc_in;
   logic      pbad_ff, pbad_in, povf_ff, povf_in, primed_ff, primed_in;

   logic            ovalid_ff, ovalid_in;
   value_type       omass_ff, omass_in, omom_ff, omom_in, oeng_ff, oeng_in;
   flux_status_type ostat_ff, ostat_in;

   iter_op_type u_op;
   value_type   u_a, u_b, u_res;
   logic        u_busy, u_done, u_ovf;

   value_type gamma_v, eps_v, pf_sel, f_sel, w_sel, pw_sel;
   sat_type   s0, s1;

   esdf_iter u_iter (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start),
      .op     (u_op),
      .a      (u_a),
      .b      (u_b),
      .busy   (u_busy),
      .done   (u_done),
      .result (u_res),
      .ovf    (u_ovf)
   );

   always_comb begin
      gamma_v = $signed(VALUE_WIDTH'(gamma_ratio));
      eps_v   = $signed(VALUE_WIDTH'(dissipation_eps));

      case (cmd.idx)
         2'd0: begin
            pf_sel = pf0_ff; f_sel = m_ff;  w_sel = rho_ff; pw_sel = prho_ff;
         end
         2'd1: begin
            pf_sel = pf1_ff; f_sel = f1_ff; w_sel = m_ff;   pw_sel = pm_ff;
         end
         default: begin
            pf_sel = pf2_ff; f_sel = f2_ff; w_sel = e_ff;   pw_sel = pe_ff;
         end
      endcase

      u_op = OP_MUL;
      u_a  = '0;
      u_b  = '0;
      case (cmd.step)
         ST_DIV_U:    begin u_op = OP_DIV;  u_a = m_ff;    u_b = rho_ff; end
         ST_MUL_MU:   begin u_op = OP_MUL;  u_a = m_ff;    u_b = u_ff;   end
         ST_MUL_P:    begin u_op = OP_MUL;  u_a = ta_ff;   u_b = tb_ff;  end
         ST_MUL_GP:   begin u_op = OP_MUL;  u_a = gamma_v; u_b = p_ff;   end
         ST_DIV_T:    begin u_op = OP_DIV;  u_a = ta_ff;   u_b = rho_ff; end
         ST_SQRT_C:   begin u_op = OP_SQRT; u_a = ta_ff;   u_b = '0;     end
         ST_MUL_F2:   begin u_op = OP_MUL;  u_a = tb_ff;   u_b = u_ff;   end
         ST_MUL_EL:   begin u_op = OP_MUL;  u_a = eps_v;   u_b = ta_ff;  end
         ST_MUL_TERM: begin u_op = OP_MUL;  u_a = el_ff;   u_b = tb_ff;  end
         default:     begin u_op = OP_MUL;  u_a = '0;      u_b = '0;     end
      endcase

      // the two saturating adders of the steps that do not use the iterative unit
      case (cmd.step)
         ST_PREP: begin
            s0 = sat_sub(gamma_v, $signed(QONE_M));
            s1 = sat_sub(e_ff, half_val(mu_ff));
         end
         ST_FLUX: begin
            s0 = sat_add(mu_ff, p_ff);
            s1 = sat_add(e_ff, p_ff);
         end
         ST_LAM1: begin
            s0 = sat_add(half_val(pu_ff), half_val(u_ff));
            s1 = sat_add(half_val(pc_ff), half_val(c_ff));
         end
         ST_LAM2: begin
            s0 = sat_add(ta_ff, tb_ff);
            s1 = sat_add('0, '0);
         end
         ST_TERM_PREP: begin
            s0 = sat_add(half_val(pf_sel), half_val(f_sel));
            s1 = sat_sub(w_sel, pw_sel);
         end
         ST_TERM_SUB: begin
            s0 = sat_sub(fa_ff, tb_ff);
            s1 = sat_add('0, '0);
         end
         default: begin
            s0 = sat_add('0, '0);
            s1 = sat_add('0, '0);
         end
      endcase

      rho_in = rho_ff; m_in = m_ff; e_in = e_ff;
      u_in = u_ff; mu_in = mu_ff; p_in = p_ff; c_in = c_ff;
      f1_in = f1_ff; f2_in = f2_ff;
      ta_in = ta_ff; tb_in = tb_ff; fa_in = fa_ff; el_in = el_ff;
      res_in = res_ff;
      no_face_in = no_face_ff; bad_in = bad_ff;
      ovf_in = ovf_ff; cell_ovf_in = cell_ovf_ff;
      prho_in = prho_ff; pm_in = pm_ff; pe_in = pe_ff;
      pf0_in = pf0_ff; pf1_in = pf1_ff; pf2_in = pf2_ff;
      pu_in = pu_ff; pc_in = pc_ff;
      pbad_in = pbad_ff; povf_in = povf_ff; primed_in = primed_ff;
      omass_in = omass_ff; omom_in = omom_ff; oeng_in = oeng_ff; ostat_in = ostat_ff;
      ovalid_in = ovalid_ff && !out_ready;

      if (cmd.load) begin
         rho_in     = in_density;
         m_in       = in_momentum;
         e_in       = in_energy;
         no_face_in = in_first || !primed_ff;
         bad_in     = in_density[VALUE_WIDTH-1] || (in_density == '0);
         ovf_in     = 1'b0;
      end

      if (u_done) begin
         ovf_in = ovf_ff || u_ovf;
         case (cmd.step)
            ST_DIV_U:    u_in  = u_res;
            ST_MUL_MU:   mu_in = u_res;
            ST_MUL_P: begin
               p_in = u_res;
               if (u_res[VALUE_WIDTH-1]) begin
                  bad_in = 1'b1;
               end
            end
            ST_MUL_GP:   ta_in = u_res;
            ST_DIV_T:    ta_in = u_res;
            ST_SQRT_C:   c_in  = u_res;
            ST_MUL_F2:   f2_in = u_res;
            ST_MUL_EL:   el_in = half_val(u_res);
            ST_MUL_TERM: tb_in = u_res;
            default:     ovf_in = ovf_ff;
         endcase
      end

      case (cmd.step)
         ST_PREP: begin
            ta_in  = s0.val;
            tb_in  = s1.val;
            ovf_in = ovf_ff || s0.ovf || s1.ovf;
         end
         ST_FLUX: begin
            f1_in  = s0.val;
            tb_in  = s1.val;
            ovf_in = ovf_ff || s0.ovf || s1.ovf;
         end
         ST_LAM1: begin
            ta_in  = s0.val;
            tb_in  = s1.val;
            ovf_in = ovf_ff || s0.ovf || s1.ovf;
         end
         ST_LAM2: begin
            ta_in  = s0.val;
            ovf_in = ovf_ff || s0.ovf;
         end
         ST_TERM_PREP: begin
            fa_in  = s0.val;
            tb_in  = s1.val;
            ovf_in = ovf_ff || s0.ovf || s1.ovf;
         end
         ST_TERM_SUB: begin
            res_in[cmd.idx] = s0.val;
            ovf_in          = ovf_ff || s0.ovf;
         end
         ST_FACE: begin
            cell_ovf_in = ovf_ff;
         end
         ST_COMMIT: begin
            prho_in   = rho_ff;
            pm_in     = m_ff;
            pe_in     = e_ff;
            pf0_in    = bad_ff ? '0 : m_ff;
            pf1_in    = bad_ff ? '0 : f1_ff;
            pf2_in    = bad_ff ? '0 : f2_ff;
            pu_in     = bad_ff ? '0 : u_ff;
            pc_in     = bad_ff ? '0 : c_ff;
            pbad_in   = bad_ff;
            povf_in   = cell_ovf_ff;
            primed_in = 1'b1;
         end
         default: begin
            cell_ovf_in = cell_ovf_ff;
         end
      endcase

      if (cmd.write_out) begin
         ovalid_in = 1'b1;
         if (bad_ff || pbad_ff) begin
            omass_in = '0;
            omom_in  = '0;
            oeng_in  = '0;
            ostat_in = FLUX_BAD;
         end else begin
            omass_in = res_ff[0];
            omom_in  = res_ff[1];
            oeng_in  = res_ff[2];
            ostat_in = (ovf_ff || povf_ff) ? FLUX_SAT : FLUX_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prho_ff   <= '0;
         pm_ff     <= '0;
         pe_ff     <= '0;
         pf0_ff    <= '0;
         pf1_ff    <= '0;
         pf2_ff    <= '0;
         pu_ff     <= '0;
         pc_ff     <= '0;
         pbad_ff   <= 1'b0;
         povf_ff   <= 1'b0;
         primed_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         prho_ff   <= prho_in;
         pm_ff     <= pm_in;
         pe_ff     <= pe_in;
         pf0_ff    <= pf0_in;
         pf1_ff    <= pf1_in;
         pf2_ff    <= pf2_in;
         pu_ff     <= pu_in;
         pc_ff     <= pc_in;
         pbad_ff   <= pbad_in;
         povf_ff   <= povf_in;
         primed_ff <= primed_in;
         ovalid_ff <= ovalid_in;
      end
      rho_ff      <= rho_in;
      m_ff        <= m_in;
      e_ff        <= e_in;
      u_ff        <= u_in;
      mu_ff       <= mu_in;
      p_ff        <= p_in;
      c_ff        <= c_in;
      f1_ff       <= f1_in;
      f2_ff       <= f2_in;
      ta_ff       <= ta_in;
      tb_ff       <= tb_in;
      fa_ff       <= fa_in;
      el_ff       <= el_in;
      res_ff      <= res_in;
      no_face_ff  <= no_face_in;
      bad_ff      <= bad_in;
      ovf_ff      <= ovf_in;
      cell_ovf_ff <= cell_ovf_in;
      omass_ff    <= omass_in;
      omom_ff     <= omom_in;
      oeng_ff     <= oeng_in;
      ostat_ff    <= ostat_in;
   end

   always_comb begin
      status.unit_busy = u_busy;
      status.unit_done = u_done;
      status.cell_bad  = bad_ff;
      status.prev_bad  = pbad_ff;
      status.no_face   = no_face_ff;
      status.out_free  = !ovalid_ff || out_ready;
   end

   assign out_valid    = ovalid_ff;
   assign out_mass     = omass_ff;
   assign out_momentum = omom_ff;
   assign out_energy   = oeng_ff;
   assign out_status   = ostat_ff;

endmodule

// ----- design/esdf_ctrl.sv -----
module esdf_ctrl import esdf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   esdf_state_type state_ff, state_in;
   logic [1:0]     idx_ff, idx_in;
   logic           unit_state;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE:      if (in_valid) state_in = ST_CHECK;
         ST_CHECK:     state_in = status.cell_bad ? ST_FACE : ST_DIV_U;
         ST_DIV_U:     if (status.unit_done) state_in = ST_MUL_MU;
         ST_MUL_MU:    if (status.unit_done) state_in = ST_PREP;
         ST_PREP:      state_in = ST_MUL_P;
         ST_MUL_P:     if (status.unit_done) state_in = ST_PCHK;
         ST_PCHK:      state_in = status.cell_bad ? ST_FACE : ST_MUL_GP;
         ST_MUL_GP:    if (status.unit_done) state_in = ST_DIV_T;
         ST_DIV_T:     if (status.unit_done) state_in = ST_SQRT_C;
         ST_SQRT_C:    if (status.unit_done) state_in = ST_FLUX;
         ST_FLUX:      state_in = ST_MUL_F2;
         ST_MUL_F2:    if (status.unit_done) state_in = ST_FACE;
         ST_FACE: begin
            idx_in = 2'd0;
            if (status.no_face) begin
               state_in = ST_COMMIT;
            end else if (status.cell_bad || status.prev_bad) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_LAM1;
            end
         end
         ST_LAM1:      state_in = ST_LAM2;
         ST_LAM2:      state_in = ST_MUL_EL;
         ST_MUL_EL:    if (status.unit_done) state_in = ST_TERM_PREP;
         ST_TERM_PREP: state_in = ST_MUL_TERM;
         ST_MUL_TERM:  if (status.unit_done) state_in = ST_TERM_SUB;
         ST_TERM_SUB: begin
            if (idx_ff == 2'd2) begin
               state_in = ST_OUT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_TERM_PREP;
            end
         end
         ST_OUT:       if (status.out_free) state_in = ST_COMMIT;
         ST_COMMIT:    state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      unit_state = state_ff inside {ST_DIV_U, ST_MUL_MU, ST_MUL_P, ST_MUL_GP, ST_DIV_T,
                                    ST_SQRT_C, ST_MUL_F2, ST_MUL_EL, ST_MUL_TERM};
      cmd.step      = state_ff;
      cmd.idx       = idx_ff;
      cmd.start     = unit_state && !status.unit_busy && !status.unit_done;
      cmd.load      = (state_ff == ST_IDLE) && in_valid;
      cmd.write_out = (state_ff == ST_OUT) && status.out_free;
      in_ready      = (state_ff == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ----- design/euler_scalar_dissipation_flux.sv -----
// channel   direction  transfer                   payload
// req_      in         req_tvalid & req_tready    tdata density/momentum/energy, tuser first_cell
// rsp_      out        rsp_tvalid & rsp_tready    tdata mass/momentum/energy flux, tuser status
// csr_      in         psel & penable & pwrite    gamma_ratio at 0x0, dissipation_eps at 0x4
//
// one cell at a time, and a first or bad cell is done sooner than a cell that yields a face;
// the time per cell is set by the shared iterative unit (two 72-step divides, a 36-step
// root, eight 3-step multiplies, each plus the handoff between sequencer states)
// a finished face flux sits in the output register, so the next cell is taken while it waits
// reset is synchronous and clears the previous-cell state; registers return to 1.4 and 0.5
module euler_scalar_dissipation_flux import esdf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // cell_density, cell_momentum, cell_energy
   input  logic [TDATA_IN_W-1:0]   req_tdata,
   // first_cell
   input  logic [0:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // face_flux_mass, face_flux_momentum, face_flux_energy
   output logic [TDATA_OUT_W-1:0]  rsp_tdata,
   // flux_status
   output logic [1:0]              rsp_tuser,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   logic [GAMMA_W-1:0] gamma_ff, gamma_in;
   logic [EPS_W-1:0]   eps_ff, eps_in;
   logic               csr_write;
   csr_reg_type        csr_sel;

   ctrl_cmd_type    cmd;
   dp_status_type   status;
   value_type       out_mass, out_mom, out_eng;
   flux_status_type out_stat;

   // register file: word address picks the register
   always_comb begin
      csr_sel   = csr_reg_type'(csr_paddr[2]);
      csr_write = csr_psel && csr_penable && csr_pwrite;
      gamma_in  = gamma_ff;
      eps_in    = eps_ff;
      if (csr_write) begin
         case (csr_sel)
            CSR_GAMMA: gamma_in = csr_pwdata[GAMMA_W-1:0];
            CSR_EPS:   eps_in   = csr_pwdata[EPS_W-1:0];
            default:   gamma_in = gamma_ff;
         endcase
      end
      case (csr_sel)
         CSR_GAMMA: csr_prdata = CSR_DATA_W'(gamma_ff);
         CSR_EPS:   csr_prdata = CSR_DATA_W'(eps_ff);
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_RESET;
         eps_ff   <= EPS_RESET;
      end else begin
         gamma_ff <= gamma_in;
         eps_ff   <= eps_in;
      end
   end

   assign csr_pready = 1'b1;

   // sequencer
   esdf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   // cell evaluation, face terms and output register
   esdf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .gamma_ratio     (gamma_ff),
      .dissipation_eps (eps_ff),
      .in_density      ($signed(req_tdata[VALUE_WIDTH-1:0])),
      .in_momentum     ($signed(req_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH])),
      .in_energy       ($signed(req_tdata[3*VALUE_WIDTH-1:2*VALUE_WIDTH])),
      .in_first        (req_tuser[0]),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_mass        (out_mass),
      .out_momentum    (out_mom),
      .out_energy      (out_eng),
      .out_status      (out_stat)
   );

   // zero fill to whole bytes
   assign rsp_tdata = TDATA_OUT_W'({out_eng, out_mom, out_mass});
   assign rsp_tuser = out_stat;

endmodule
